### rtl/afc_pkg.sv
// Shared types and widths for the box versus frustum culling test.
package afc_pkg;

    // Coordinate width: signed Q16.8.
    localparam int unsigned COORD_W = 24;
    // Plane coefficient width: signed Q1.14.
    localparam int unsigned COEF_W = 16;
    // One packed plane register: a, b, c, d from low to high.
    localparam int unsigned PLANE_W = 4 * COEF_W;
    // Coefficient times coordinate, exact.
    localparam int unsigned PROD_W = COORD_W + COEF_W;
    // Plane distance sum: six products plus the aligned offset, with margin.
    localparam int unsigned SUM_W = PROD_W + 4;
    // The offset d carries 14 fraction bits; products carry 22.
    localparam int unsigned D_ALIGN = 8;
    // Plane count field and configuration index widths.
    localparam int unsigned CNT_W = 3;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        t_coord org_x;
        t_coord org_y;
        t_coord org_z;
        t_coord size_x;
        t_coord size_y;
        t_coord size_z;
    } t_box;

endpackage

### rtl/afc_plane_eval.sv
// Three-stage evaluation of one frustum plane against the farthest box corner.
module afc_plane_eval (
    input  logic                          i_clk,
    input  logic [afc_pkg::PLANE_W-1:0]   i_plane,
    input  afc_pkg::t_box                 i_box,
    output logic                          o_outside
);

    afc_pkg::t_coef a;
    afc_pkg::t_coef b;
    afc_pkg::t_coef c;
    afc_pkg::t_coef d;

    logic signed [afc_pkg::PROD_W-1:0] n_pax, n_pby, n_pcz;
    logic signed [afc_pkg::PROD_W-1:0] n_psx, n_psy, n_psz;
    logic signed [afc_pkg::PROD_W-1:0] r_pax, r_pby, r_pcz;
    logic signed [afc_pkg::PROD_W-1:0] r_psx, r_psy, r_psz;
    logic signed [afc_pkg::SUM_W-1:0]  n_d_al, r_d_al;
    logic signed [afc_pkg::SUM_W-1:0]  n_base, r_base;
    logic signed [afc_pkg::SUM_W-1:0]  n_ext, r_ext;
    logic signed [afc_pkg::SUM_W-1:0]  n_total;
    logic signed [afc_pkg::SUM_W-1:0]  ext_x, ext_y, ext_z;
    logic                              r_outside;

    assign a = afc_pkg::t_coef'(i_plane[1*afc_pkg::COEF_W-1 -: afc_pkg::COEF_W]);
    assign b = afc_pkg::t_coef'(i_plane[2*afc_pkg::COEF_W-1 -: afc_pkg::COEF_W]);
    assign c = afc_pkg::t_coef'(i_plane[3*afc_pkg::COEF_W-1 -: afc_pkg::COEF_W]);
    assign d = afc_pkg::t_coef'(i_plane[4*afc_pkg::COEF_W-1 -: afc_pkg::COEF_W]);

    // Stage 2: the origin terms and the per-axis extent terms.
    assign n_pax  = a * i_box.org_x;
    assign n_pby  = b * i_box.org_y;
    assign n_pcz  = c * i_box.org_z;
    assign n_psx  = a * i_box.size_x;
    assign n_psy  = b * i_box.size_y;
    assign n_psz  = c * i_box.size_z;
    assign n_d_al = afc_pkg::SUM_W'(d) <<< afc_pkg::D_ALIGN;

    // Stage 3: the corner farthest along the normal takes an extent term only
    // where it adds a positive amount.
    assign ext_x  = r_psx[afc_pkg::PROD_W-1] ? '0 : afc_pkg::SUM_W'(r_psx);
    assign ext_y  = r_psy[afc_pkg::PROD_W-1] ? '0 : afc_pkg::SUM_W'(r_psy);
    assign ext_z  = r_psz[afc_pkg::PROD_W-1] ? '0 : afc_pkg::SUM_W'(r_psz);
    assign n_base = afc_pkg::SUM_W'(r_pax) + afc_pkg::SUM_W'(r_pby)
                  + afc_pkg::SUM_W'(r_pcz) + r_d_al;
    assign n_ext  = ext_x + ext_y + ext_z;

    // Stage 4: all corners are outside when even the farthest one is.
    assign n_total = r_base + r_ext;

    always_ff @(posedge i_clk) begin
        r_pax     <= n_pax;
        r_pby     <= n_pby;
        r_pcz     <= n_pcz;
        r_psx     <= n_psx;
        r_psy     <= n_psy;
        r_psz     <= n_psz;
        r_d_al    <= n_d_al;
        r_base    <= n_base;
        r_ext     <= n_ext;
        r_outside <= n_total[afc_pkg::SUM_W-1];
    end

    assign o_outside = r_outside;

endmodule

### rtl/aabb_frustum_cull_test_core.sv
// Top level of the pipelined axis-aligned box versus view-frustum culling test.
//
//  Channel   Ports                                        Transfer
//  -------   -------------------------------------------  ---------------------------------
//  box in    start, busy, i_origin_*, i_size_*,            edge with start high, busy low
//            i_plane_count
//  result    o_valid, o_visible                            edge that ends the o_valid cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_data                edge with i_cfg_we high
//
// One box is taken in every cycle while busy is low. The result of a box transfers after
// it has passed the input register, multiply stage, partial-sum stage, plane-sign stage
// and the output register, all with valid bits beside them. Reset is synchronous and
// active low; it clears the valid bits and the plane registers, and busy is high during
// reset and the cycle after. The receiver cannot stall, so the pipeline never stops.
module aabb_frustum_cull_test_core #(
    parameter int unsigned PLANE_SLOTS = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [afc_pkg::COORD_W-1:0] i_origin_x,
    input  logic signed [afc_pkg::COORD_W-1:0] i_origin_y,
    input  logic signed [afc_pkg::COORD_W-1:0] i_origin_z,
    input  logic signed [afc_pkg::COORD_W-1:0] i_size_x,
    input  logic signed [afc_pkg::COORD_W-1:0] i_size_y,
    input  logic signed [afc_pkg::COORD_W-1:0] i_size_z,
    input  logic [afc_pkg::CNT_W-1:0]       i_plane_count,
    input  logic                            i_cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [afc_pkg::PLANE_W-1:0]     i_cfg_data,
    output logic                            o_valid,
    output logic                            o_visible
);

    localparam int unsigned STAGES = 4;

    logic [afc_pkg::PLANE_W-1:0] r_plane [PLANE_SLOTS];
    logic                        r_busy;
    logic                        accept;
    afc_pkg::t_box               r_box;
    logic [STAGES-1:0]           r_vld;
    logic [PLANE_SLOTS-1:0]      n_sel;
    logic [PLANE_SLOTS-1:0]      r_sel [STAGES];
    logic [PLANE_SLOTS-1:0]      outside;
    logic                        r_valid;
    logic                        r_visible;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // Plane registers; a write to an index with no slot behind it is dropped.
    for (genvar p = 0; p < PLANE_SLOTS; p++) begin : g_plane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_plane[p] <= '0;
            end else if (i_cfg_we && i_cfg_idx == afc_pkg::CFG_IDX_W'(p)) begin
                r_plane[p] <= i_cfg_data;
            end
        end

        // A plane is tested when it lies below the requested count. Counts of
        // zero or above the slot count select nothing, which rejects the box.
        assign n_sel[p] = (i_plane_count <= afc_pkg::CNT_W'(PLANE_SLOTS))
                       && (i_plane_count > afc_pkg::CNT_W'(p));

        afc_plane_eval u_eval (
            .i_clk     (i_clk),
            .i_plane   (r_plane[p]),
            .i_box     (r_box),
            .o_outside (outside[p])
        );
    end

    // Control: busy after reset, valid bits for each stage and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_vld   <= {r_vld[STAGES-2:0], accept};
            r_valid <= r_vld[STAGES-1];
        end
    end

    // Payload: the box, the plane selection travelling beside it, and the verdict.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_box.org_x  <= i_origin_x;
            r_box.org_y  <= i_origin_y;
            r_box.org_z  <= i_origin_z;
            r_box.size_x <= i_size_x;
            r_box.size_y <= i_size_y;
            r_box.size_z <= i_size_z;
            r_sel[0]     <= n_sel;
        end
        for (int s = 1; s < STAGES; s++) begin
            r_sel[s] <= r_sel[s-1];
        end
        r_visible <= (|r_sel[STAGES-1]) && !(|(r_sel[STAGES-1] & outside));
    end

    assign o_valid   = r_valid;
    assign o_visible = r_visible;

    // Every transfer yields exactly one result.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##5 o_valid)
        else $error("box transfer produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 5))
        else $error("result without a box transfer");

    // A box reported visible must have asked for a usable number of planes.
    a_count_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |-> ($past(i_plane_count, 5) != '0)
            && ($past(i_plane_count, 5) <= afc_pkg::CNT_W'(PLANE_SLOTS)))
        else $error("visible result for an empty or oversized plane count");

endmodule

### tb/aabb_frustum_cull_test_core_tb.sv
// Self-checking testbench for the box versus view-frustum culling block.
`timescale 1ns / 100ps

module aabb_frustum_cull_test_core_tb;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int unsigned PLANE_SLOTS = 6;

    localparam int RESULT_LATENCY = 5;

    // Longest quiet stretch in a correct run is the reset plus a drain and a
    // plane reload; the limit leaves a wide margin over that.
    localparam int QUIET_LIMIT = 1000;

    // Random boxes per idle phase; three phases make about 830 boxes, which
    // together with the directed rows gives roughly 850 transfers.
    localparam int PHASE_ITEMS = 276;

    // Fixed-point coefficient values in signed Q1.14.
    localparam logic [afc_pkg::COEF_W-1:0] Q_ZERO = 16'h0000;
    localparam logic [afc_pkg::COEF_W-1:0] Q_ONE  = 16'h4000;
    localparam logic [afc_pkg::COEF_W-1:0] Q_HALF = 16'h2000;
    localparam logic [afc_pkg::COEF_W-1:0] Q_DIAG = 16'h2D41;   // about 0.7071
    localparam logic [afc_pkg::COEF_W-1:0] Q_MAX  = 16'h7FFF;
    localparam logic [afc_pkg::COEF_W-1:0] Q_MIN  = 16'h8000;

    // Coordinate extremes in signed Q16.8.
    localparam afc_pkg::t_coord C_MAX = 24'h7FFFFF;
    localparam afc_pkg::t_coord C_MIN = 24'h800000;

    // Register indexes of the configuration port. The last two are unused
    // slots; writes to them must leave every plane untouched.
    typedef enum logic [afc_pkg::CFG_IDX_W-1:0] {
        REG_NEAR,
        REG_RIGHT,
        REG_LEFT,
        REG_TOP,
        REG_BOTTOM,
        REG_FAR,
        REG_SPARE_A,
        REG_SPARE_B
    } t_plane_reg;

    // One row of the directed stimulus. When pinned is set, the expected
    // result is typed into the row; otherwise the predictor supplies it.
    typedef struct packed {
        afc_pkg::t_box box;
        logic [2:0]    count;
        logic          pinned;
        logic          pinned_visible;
    } t_box_row;

    // Rows from the first one up to FRUSTUM_ROW run with the planes as reset
    // left them: every plane is all zero, so no corner is ever outside and a
    // box is visible whenever its plane count is in range.
    localparam int FRUSTUM_ROW = 8;
    localparam int DIR_ROWS    = 22;

    t_box_row dir_rows [DIR_ROWS] = '{
        // Planes at reset: results follow from the plane count alone.
        '{'{0, 0, 0, 0, 0, 0}, 3'd0, 1'b1, 1'b0},
        '{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 3'd7, 1'b1, 1'b0},
        '{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, 3'd6, 1'b1, 1'b1},
        '{'{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN}, 3'd1, 1'b1, 1'b1},
        '{'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX}, 3'd3, 1'b1, 1'b1},
        '{'{100, -100, 300, 0, 0, 0}, 3'd6, 1'b1, 1'b1},
        '{'{C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN}, 3'd0, 1'b1, 1'b0},
        '{'{C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX}, 3'd7, 1'b1, 1'b0},
        // Frustum planes loaded: results come from the predictor.
        '{'{0, 0, 384, 0, 0, 0}, 3'd6, 1'b0, 1'b0},
        '{'{0, 0, 0, 0, 0, 0}, 3'd6, 1'b0, 1'b0},
        '{'{0, 0, 768, 0, 0, 0}, 3'd6, 1'b0, 1'b0},
        '{'{-64, -64, -64, 128, 128, 256}, 3'd6, 1'b0, 1'b0},
        '{'{1024, 0, 256, 64, 64, 64}, 3'd2, 1'b0, 1'b0},
        '{'{1024, 0, 256, 64, 64, 64}, 3'd1, 1'b0, 1'b0},
        '{'{1024, 0, 320, -2048, -64, -64}, 3'd6, 1'b0, 1'b0},
        '{'{-1024, 0, 256, 64, 64, 64}, 3'd3, 1'b0, 1'b0},
        '{'{0, 1024, 256, 64, 64, 64}, 3'd4, 1'b0, 1'b0},
        '{'{0, -1024, 256, 64, 64, 64}, 3'd5, 1'b0, 1'b0},
        '{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 3'd6, 1'b0, 1'b0},
        '{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, 3'd6, 1'b0, 1'b0},
        '{'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX}, 3'd6, 1'b0, 1'b0},
        '{'{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN}, 3'd4, 1'b0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    afc_pkg::t_coord i_origin_x, i_origin_y, i_origin_z;
    afc_pkg::t_coord i_size_x, i_size_y, i_size_z;
    logic [afc_pkg::CNT_W-1:0] i_plane_count;
    logic i_cfg_we;
    logic [afc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [afc_pkg::PLANE_W-1:0] i_cfg_data;
    logic o_valid;
    logic o_visible;

    // Travel with each box: a typed expectation that replaces the prediction.
    logic pin_valid;
    logic pin_visible;

    // Private copy of the six plane registers, updated on every write to a
    // plane index seen on the configuration port.
    logic [afc_pkg::PLANE_W-1:0] plane_model [PLANE_SLOTS];

    // Planes that the next reload writes.
    logic [afc_pkg::PLANE_W-1:0] plane_set [PLANE_SLOTS];

    logic expected_visible [$];
    int unsigned fault_count = 0;
    int quiet_cycles = 0;
    int unsigned idle_pct = 0;

    aabb_frustum_cull_test_core #(
        .PLANE_SLOTS(PLANE_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_origin_x(i_origin_x),
        .i_origin_y(i_origin_y),
        .i_origin_z(i_origin_z),
        .i_size_x(i_size_x),
        .i_size_y(i_size_y),
        .i_size_z(i_size_z),
        .i_plane_count(i_plane_count),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_visible(o_visible)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Packs the coefficients of a*x + b*y + c*z + d with a in the lowest field.
    function automatic logic [afc_pkg::PLANE_W-1:0] pack_plane(
            input logic [afc_pkg::COEF_W-1:0] a,
            input logic [afc_pkg::COEF_W-1:0] b,
            input logic [afc_pkg::COEF_W-1:0] c,
            input logic [afc_pkg::COEF_W-1:0] d);
        return {d, c, b, a};
    endfunction

    // Predicts the visibility of a box against the leading planes of the
    // model. Corners are exact 25-bit sums, products and the offset aligned
    // to 22 fraction bits are summed exactly, and only the sign matters.
    function automatic logic box_in_frustum(input afc_pkg::t_box b,
                                            input logic [2:0] count);
        logic signed [afc_pkg::COORD_W:0] xs [2];
        logic signed [afc_pkg::COORD_W:0] ys [2];
        logic signed [afc_pkg::COORD_W:0] zs [2];
        logic signed [afc_pkg::COEF_W-1:0] ca, cb, cc, cd;
        logic signed [afc_pkg::SUM_W-1:0] d_term;
        logic signed [afc_pkg::SUM_W-1:0] plane_sum;
        logic any_inside;
        logic vis;
        if (count == 0 || count > PLANE_SLOTS) begin
            return 1'b0;
        end
        xs[0] = b.org_x;
        xs[1] = b.org_x + b.size_x;
        ys[0] = b.org_y;
        ys[1] = b.org_y + b.size_y;
        zs[0] = b.org_z;
        zs[1] = b.org_z + b.size_z;
        vis = 1'b1;
        for (int p = 0; p < count; p++) begin
            {cd, cc, cb, ca} = plane_model[p];
            d_term = cd;
            d_term = d_term <<< afc_pkg::D_ALIGN;
            any_inside = 1'b0;
            // Corner k takes the far end of axis n when bit n of k is set.
            for (int k = 0; k < 8; k++) begin
                plane_sum = ca * xs[k & 1] + cb * ys[(k >> 1) & 1]
                          + cc * zs[(k >> 2) & 1] + d_term;
                if (plane_sum >= 0) begin
                    any_inside = 1'b1;
                end
            end
            // All eight corners outside one plane rejects the box.
            if (!any_inside) begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    // A span of zero asks for any value the field can hold; otherwise the
    // value is drawn from minus span to plus span.
    function automatic afc_pkg::t_coord rand_coord(input int unsigned span);
        if (span == 0) begin
            return afc_pkg::t_coord'($urandom);
        end
        return afc_pkg::t_coord'(int'($urandom_range(0, 2 * span)) - int'(span));
    endfunction

    // Presents one box, idling first at the current rate, and returns right
    // after the edge at which the box transfers.
    task automatic send_box(input afc_pkg::t_box b, input logic [2:0] count,
                            input logic pin, input logic pin_vis);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_origin_x    <= b.org_x;
        i_origin_y    <= b.org_y;
        i_origin_z    <= b.org_z;
        i_size_x      <= b.size_x;
        i_size_y      <= b.size_y;
        i_size_z      <= b.size_z;
        i_plane_count <= count;
        pin_valid     <= pin;
        pin_visible   <= pin_vis;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every predicted result has come back. The
    // first edge is always waited for, so the prediction of the last box is
    // already queued when the queue is looked at.
    task automatic drain_results();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_visible.size() != 0);
    endtask

    // Writes every plane from plane_set, then both unused indexes with random
    // data, keeping the write enable high across the whole burst.
    task automatic load_planes();
        for (int r = REG_NEAR; r <= REG_SPARE_B; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= afc_pkg::CFG_IDX_W'(r);
            i_cfg_data <= (r <= REG_FAR) ? plane_set[r] : {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Everything on the ports is sampled here, at the rising edge, so both
    // the inputs driven by this bench and the outputs of the block still
    // hold the values of the cycle that the edge ends.
    always @(posedge i_clk) begin : observe
        logic want;
        if (i_rst_n && i_cfg_we && i_cfg_idx <= REG_FAR) begin
            plane_model[i_cfg_idx] = i_cfg_data;
        end
        if (i_rst_n && start && !busy) begin
            if (pin_valid) begin
                expected_visible.push_back(pin_visible);
            end else begin
                expected_visible.push_back(box_in_frustum(
                    afc_pkg::t_box'{i_origin_x, i_origin_y, i_origin_z,
                                    i_size_x, i_size_y, i_size_z},
                    i_plane_count));
            end
        end
        if (i_rst_n && o_valid) begin
            if (expected_visible.size() == 0) begin
                $error("visible: result with no box outstanding, actual %0b", o_visible);
                fault_count++;
            end else begin
                want = expected_visible.pop_front();
                if (o_visible !== want) begin
                    $error("visible: expected %0b, actual %0b", want, o_visible);
                    fault_count++;
                end
            end
        end
        // The watchdog only counts cycles with neither a box nor a result.
        if (i_rst_n && ((start && !busy) || o_valid)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        afc_pkg::t_box box;
        logic [2:0] count;
        int unsigned org_span;
        int unsigned size_span;
        int unsigned pick;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_origin_x    <= '0;
        i_origin_y    <= '0;
        i_origin_z    <= '0;
        i_size_x      <= '0;
        i_size_y      <= '0;
        i_size_z      <= '0;
        i_plane_count <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        pin_valid     <= 1'b0;
        pin_visible   <= 1'b0;
        foreach (plane_model[p]) begin
            plane_model[p] = '0;
        end

        // A symmetric frustum looking down +z: near at z = 0.5, far at about
        // z = 2, and four side planes at 45 degrees.
        plane_set[REG_NEAR]   = pack_plane(Q_ZERO, Q_ZERO, Q_ONE, -Q_HALF);
        plane_set[REG_RIGHT]  = pack_plane(-Q_DIAG, Q_ZERO, Q_DIAG, Q_ZERO);
        plane_set[REG_LEFT]   = pack_plane(Q_DIAG, Q_ZERO, Q_DIAG, Q_ZERO);
        plane_set[REG_TOP]    = pack_plane(Q_ZERO, -Q_DIAG, Q_DIAG, Q_ZERO);
        plane_set[REG_BOTTOM] = pack_plane(Q_ZERO, Q_DIAG, Q_DIAG, Q_ZERO);
        plane_set[REG_FAR]    = pack_plane(Q_ZERO, Q_ZERO, -Q_ONE, Q_MAX);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows. The block is drained before the frustum is loaded so
        // that no box is in flight while a plane changes.
        idle_pct = 23;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (r == FRUSTUM_ROW) begin
                drain_results();
                load_planes();
            end
            send_box(dir_rows[r].box, dir_rows[r].count,
                     dir_rows[r].pinned, dir_rows[r].pinned_visible);
        end

        // Random phases: the sender idles in 23, then 73 and then 0 percent
        // of cycles. Each phase pauses halfway until all results are back,
        // and reloads planes at its start and midpoint.
        // The first phase keeps the frustum, the second uses coefficients at
        // their extremes, including an all-rejecting and an all-zero plane,
        // and the third draws fresh random planes at each reload.
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 23 : (ph == 1) ? 73 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 0 || n == PHASE_ITEMS / 2) begin
                    drain_results();
                    if (ph == 2) begin
                        foreach (plane_set[p]) begin
                            plane_set[p] = {$urandom, $urandom};
                        end
                    end else if (ph == 1 && n == 0) begin
                        plane_set[REG_NEAR]   = pack_plane(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
                        plane_set[REG_RIGHT]  = pack_plane(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
                        plane_set[REG_LEFT]   = pack_plane(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
                        plane_set[REG_TOP]    = pack_plane(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
                        plane_set[REG_BOTTOM] = pack_plane(Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN);
                        plane_set[REG_FAR]    = pack_plane(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
                    end
                    load_planes();
                end

                // Plane offsets reach only about two units, so most origins
                // stay within four units of the apex where results vary; the
                // rest span the whole field.
                org_span   = ($urandom_range(0, 9) < 6) ? 1024 : 0;
                box.org_x  = rand_coord(org_span);
                box.org_y  = rand_coord(org_span);
                box.org_z  = rand_coord(org_span);
                pick       = $urandom_range(0, 19);
                size_span  = (pick < 12) ? 512 : (pick < 17) ? 65536 : 0;
                box.size_x = rand_coord(size_span);
                box.size_y = rand_coord(size_span);
                box.size_z = rand_coord(size_span);
                if ($urandom_range(0, 9) == 0) begin
                    count = ($urandom_range(0, 1) == 1) ? 3'd7 : 3'd0;
                end else begin
                    count = 3'($urandom_range(1, PLANE_SLOTS));
                end
                // Point test: a box of zero size against all six planes.
                if (pick == 0) begin
                    box.size_x = '0;
                    box.size_y = '0;
                    box.size_z = '0;
                    count      = 3'(PLANE_SLOTS);
                end
                send_box(box, count, 1'b0, 1'b0);
            end
        end

        drain_results();
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
        if (fault_count == 0 && expected_visible.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
